@@ design/sdn_pkg.sv @@
`default_nettype none
package sdn_pkg;
    localparam int COORD_W = 32;
    localparam int SUM_W   = 2 * COORD_W;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int LEN_W   = 31;
    localparam int Q_W     = 17;
    localparam int DIR_W   = Q_W + 1;
    localparam int FRAC_W  = 16;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef logic signed [COORD_W-1:0] t_coord;
endpackage
`default_nettype wire

@@ design/sdn_sqrt.sv @@
`default_nettype none
module sdn_sqrt
    import sdn_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [SUM_W-1:0]   i_sum,
    input  wire t_coord             i_dx,
    input  wire t_coord             i_dz,
    output logic                    o_valid,
    output logic [ROOT_W-1:0]       o_root,
    output t_coord                  o_dx,
    output t_coord                  o_dz
);
    localparam int REM_W = ROOT_W + 2;

    logic               vld  [0:ROOT_W];
    logic [SUM_W-1:0]   rad  [0:ROOT_W];
    logic [REM_W-1:0]   rem  [0:ROOT_W];
    logic [ROOT_W-1:0]  root [0:ROOT_W];
    t_coord             sx   [0:ROOT_W];
    t_coord             sz   [0:ROOT_W];

    assign vld[0]  = i_valid;
    assign rad[0]  = i_sum;
    assign rem[0]  = '0;
    assign root[0] = '0;
    assign sx[0]   = i_dx;
    assign sz[0]   = i_dz;

    // one result bit per stage
    for (genvar s = 0; s < ROOT_W; s++) begin : g_step
        logic [REM_W+1:0] w_cat;
        logic [REM_W+2:0] w_trial;

        assign w_cat   = {rem[s], rad[s][SUM_W-1 -: 2]};
        assign w_trial = {1'b0, w_cat} - {3'b000, root[s], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                vld[s+1] <= 1'b0;
            end else if (i_en) begin
                vld[s+1] <= vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                rad[s+1] <= {rad[s][SUM_W-3:0], 2'b00};
                sx[s+1]  <= sx[s];
                sz[s+1]  <= sz[s];
                if (!w_trial[REM_W+2]) begin
                    rem[s+1]  <= w_trial[REM_W-1:0];
                    root[s+1] <= {root[s][ROOT_W-2:0], 1'b1};
                end else begin
                    rem[s+1]  <= w_cat[REM_W-1:0];
                    root[s+1] <= {root[s][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = vld[ROOT_W];
    assign o_root  = root[ROOT_W];
    assign o_dx    = sx[ROOT_W];
    assign o_dz    = sz[ROOT_W];
endmodule
`default_nettype wire

@@ design/sdn_div.sv @@
`default_nettype none
module sdn_div
    import sdn_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire t_coord             i_dx,
    input  wire t_coord             i_dz,
    input  wire logic [LEN_W-1:0]   i_len,
    output logic                    o_valid,
    output logic [Q_W-1:0]          o_qx,
    output logic [Q_W-1:0]          o_qz,
    output logic                    o_neg_x,
    output logic                    o_neg_z,
    output logic [LEN_W-1:0]        o_len
);
    localparam int NUM_W = COORD_W + FRAC_W;

    logic               vld  [0:Q_W];
    logic [LEN_W-1:0]   len  [0:Q_W];
    logic [NUM_W-1:0]   rx   [0:Q_W];
    logic [NUM_W-1:0]   rz   [0:Q_W];
    logic [Q_W-1:0]     qx   [0:Q_W];
    logic [Q_W-1:0]     qz   [0:Q_W];
    logic               nx   [0:Q_W];
    logic               nz   [0:Q_W];
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] az;

    assign ax = i_dx[COORD_W-1] ? (~i_dx + 1'b1) : i_dx;
    assign az = i_dz[COORD_W-1] ? (~i_dz + 1'b1) : i_dz;

    assign vld[0] = i_valid;
    assign len[0] = i_len;
    assign rx[0]  = {ax, {FRAC_W{1'b0}}};
    assign rz[0]  = {az, {FRAC_W{1'b0}}};
    assign qx[0]  = '0;
    assign qz[0]  = '0;
    assign nx[0]  = i_dx[COORD_W-1];
    assign nz[0]  = i_dz[COORD_W-1];

    // restoring division, quotient msb first
    for (genvar k = 0; k < Q_W; k++) begin : g_step
        localparam int SH = Q_W - 1 - k;
        logic [NUM_W:0] w_den;
        logic [NUM_W:0] w_tx;
        logic [NUM_W:0] w_tz;

        assign w_den = {{(NUM_W+1-LEN_W){1'b0}}, len[k]} << SH;
        assign w_tx  = {1'b0, rx[k]} - w_den;
        assign w_tz  = {1'b0, rz[k]} - w_den;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                vld[k+1] <= 1'b0;
            end else if (i_en) begin
                vld[k+1] <= vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                len[k+1] <= len[k];
                nx[k+1]  <= nx[k];
                nz[k+1]  <= nz[k];
                rx[k+1]  <= w_tx[NUM_W] ? rx[k] : w_tx[NUM_W-1:0];
                rz[k+1]  <= w_tz[NUM_W] ? rz[k] : w_tz[NUM_W-1:0];
                qx[k+1]  <= {qx[k][Q_W-2:0], ~w_tx[NUM_W]};
                qz[k+1]  <= {qz[k][Q_W-2:0], ~w_tz[NUM_W]};
            end
        end
    end

    assign o_valid = vld[Q_W];
    assign o_qx    = qx[Q_W];
    assign o_qz    = qz[Q_W];
    assign o_neg_x = nx[Q_W];
    assign o_neg_z = nz[Q_W];
    assign o_len   = len[Q_W];
endmodule
`default_nettype wire

@@ design/segment_direction_normalize_core.sv @@
`default_nettype none
// segment direction normalizer, 2d, signed 16.16 fixed point
// input channel: i_valid / o_stall carrying the two endpoints of a segment;
//   a word is taken at a clock edge with i_valid high and o_stall low
// output channel: o_valid / i_stall carrying the unit direction and length
// stages: 4 front stages, one stage per root bit over 32 bits, one stage per
//   quotient bit over 17 bits, one output stage
// throughput: one word per cycle unless i_stall holds the output word; every
//   stage is a register and the root and divider advance one bit per stage
// stall: the whole pipe moves on a single enable; when the output word waits
//   under i_stall every stage holds and o_stall goes high, nothing dropped
// reset: i_rst_n low clears all valid bits, the pipe comes up empty
// zero length gives a zero direction; length saturates at 0x7fffffff
module segment_direction_normalize_core
    import sdn_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic signed [COORD_W-1:0] i_start_x,
    input  wire logic signed [COORD_W-1:0] i_start_z,
    input  wire logic signed [COORD_W-1:0] i_end_x,
    input  wire logic signed [COORD_W-1:0] i_end_z,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [DIR_W-1:0]      o_dir_x,
    output logic signed [DIR_W-1:0]      o_dir_z,
    output logic [LEN_W-1:0]             o_seg_length
);
    logic w_en;

    // front stages
    logic                r_v1, r_v2, r_v3, r_v4;
    t_coord              r_dx1, r_dz1, r_dx2, r_dz2, r_dx3, r_dz3, r_dx4, r_dz4;
    logic [COORD_W-1:0]  r_ax2, r_az2;
    logic [SUM_W-1:0]    r_px3, r_pz3, r_sum4;

    // root and divider
    logic                w_sv;
    logic [ROOT_W-1:0]   w_root;
    t_coord              w_sdx, w_sdz;
    logic [LEN_W-1:0]    w_len;
    logic                w_dv, w_nx, w_nz;
    logic [Q_W-1:0]      w_qx, w_qz;
    logic [LEN_W-1:0]    w_dlen;
    logic [DIR_W-1:0]    w_mx, w_mz;

    logic                r_out_v;
    logic [DIR_W-1:0]    r_dir_x, r_dir_z;
    logic [LEN_W-1:0]    r_len;

    // whole pipe advances unless the output word is held
    assign w_en    = !(r_out_v && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // deltas wrap at 32 bits
            r_dx1  <= i_end_x - i_start_x;
            r_dz1  <= i_end_z - i_start_z;
            // magnitudes, 0x80000000 stays as unsigned 2^31
            r_dx2  <= r_dx1;
            r_dz2  <= r_dz1;
            r_ax2  <= r_dx1[COORD_W-1] ? (~r_dx1 + 1'b1) : r_dx1;
            r_az2  <= r_dz1[COORD_W-1] ? (~r_dz1 + 1'b1) : r_dz1;
            // squares
            r_dx3  <= r_dx2;
            r_dz3  <= r_dz2;
            r_px3  <= SUM_W'(r_ax2) * SUM_W'(r_ax2);
            r_pz3  <= SUM_W'(r_az2) * SUM_W'(r_az2);
            // sum fits in 64 bits
            r_dx4  <= r_dx3;
            r_dz4  <= r_dz3;
            r_sum4 <= r_px3 + r_pz3;
        end
    end

    sdn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_sum   (r_sum4),
        .i_dx    (r_dx4),
        .i_dz    (r_dz4),
        .o_valid (w_sv),
        .o_root  (w_root),
        .o_dx    (w_sdx),
        .o_dz    (w_sdz)
    );

    // saturate the length before it divides
    assign w_len = w_root[ROOT_W-1] ? LEN_MAX : w_root[LEN_W-1:0];

    sdn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sv),
        .i_dx    (w_sdx),
        .i_dz    (w_sdz),
        .i_len   (w_len),
        .o_valid (w_dv),
        .o_qx    (w_qx),
        .o_qz    (w_qz),
        .o_neg_x (w_nx),
        .o_neg_z (w_nz),
        .o_len   (w_dlen)
    );

    assign w_mx = {1'b0, w_qx};
    assign w_mz = {1'b0, w_qz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_dv;
        end
    end

    // sign back on, truncation toward zero; zero length forces zero direction
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_len <= w_dlen;
            if (w_dlen == '0) begin
                r_dir_x <= '0;
                r_dir_z <= '0;
            end else begin
                r_dir_x <= w_nx ? (~w_mx + 1'b1) : w_mx;
                r_dir_z <= w_nz ? (~w_mz + 1'b1) : w_mz;
            end
        end
    end

    assign o_valid      = r_out_v;
    assign o_dir_x      = r_dir_x;
    assign o_dir_z      = r_dir_z;
    assign o_seg_length = r_len;
endmodule
`default_nettype wire

@@ design/sdn_checker.sv @@
`default_nettype none
module sdn_checker
    import sdn_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_stall,
    input wire logic                    o_valid,
    input wire logic                    i_stall,
    input wire logic signed [DIR_W-1:0] o_dir_x,
    input wire logic signed [DIR_W-1:0] o_dir_z,
    input wire logic [LEN_W-1:0]        o_seg_length
);
    localparam logic signed [DIR_W-1:0] ONE     = DIR_W'(1 << FRAC_W);
    localparam logic signed [DIR_W-1:0] NEG_ONE = -ONE;

    // pipe comes up empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

    // input stalls only behind a held output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output word");

    // held output word does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_dir_x) && $stable(o_dir_z)
                                  && $stable(o_seg_length)))
        else $error("stalled output word changed");

    // direction is a unit vector component, zero for zero length
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dir_x <= ONE && o_dir_x >= NEG_ONE && o_dir_z <= ONE
                     && o_dir_z >= NEG_ONE
                     && (o_seg_length != '0 || (o_dir_x == '0 && o_dir_z == '0))))
        else $error("direction out of range");
endmodule

bind segment_direction_normalize_core sdn_checker u_sdn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_dir_x      (o_dir_x),
    .o_dir_z      (o_dir_z),
    .o_seg_length (o_seg_length)
);
`default_nettype wire
